/* src/bst_pkg.sv */
// bst_pkg: shared types and codes for the bounded set table.
// Field widths, command and status codes, and the controller state type.
// Used by the channel interfaces and by bounded_set_table_top.
`default_nettype none

package bst_pkg;

  // payload field widths
  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;
  localparam int SIZE_W   = 5;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_DUP     = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_MISSING = 2'd3;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE_RD,
    S_MOVE_WR,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

/* src/bst_cmd_if.sv */
// bst_cmd_if: command channel (valid/ready plus command and value).
// Depends on bst_pkg for field widths.
`default_nettype none

interface bst_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [bst_pkg::CMD_W-1:0]      command;
  logic [bst_pkg::VALUE_W-1:0]    value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

`default_nettype wire

/* src/bst_res_if.sv */
// bst_res_if: result channel (valid/ready plus status, position and size).
// Depends on bst_pkg for field widths.
`default_nettype none

interface bst_res_if;
  logic                           valid;
  logic                           ready;
  logic [bst_pkg::STATUS_W-1:0]   status;
  logic [bst_pkg::POS_W-1:0]      position;
  logic [bst_pkg::SIZE_W-1:0]     size;

  modport source (output valid, output status, output position, output size, input ready);
  modport sink   (input valid, input status, input position, input size, output ready);
endinterface

`default_nettype wire

/* src/bounded_set_table_top.sv */
// bounded_set_table_top: fixed-capacity set of distinct values.
// Depends on bst_pkg, bst_cmd_if and bst_res_if.
//
// Usage:
//   cmd : one beat per command (add, remove, lookup, clear) with its value.
//   res : exactly one beat per command: status, position and size after it.
//   The entries live in a single-port-read, single-port-write memory with a
//   registered read. A command is taken only while the controller is idle;
//   the block works on one command at a time.
// Sequence:
//   Clear, and add to a full set, skip the scan: the controller goes from
//   idle straight to the result state. Add, lookup and remove scan the
//   entries; a remove that finds its value then reads the last entry and
//   writes it into the freed slot. After the result beat the controller
//   returns to idle before a new command is taken. The scan issues one
//   memory read per cycle and compares the previous read, so the scan
//   length follows the entry count.
// Reset:
//   rst empties the set (count to zero) and idles the controller; the
//   memory itself is not cleared, as only entries below count are read.
// Stall:
//   The result holds in its output register while res.ready is low, and no
//   new command is taken until that beat has gone.
`default_nettype none

module bounded_set_table_top #(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  bst_cmd_if.sink   cmd,
  bst_res_if.source res
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // entry storage
  logic [VALUE_BITS-1:0] mem [CAPACITY];
  logic [VALUE_BITS-1:0] rd_data;
  logic [IDX_W-1:0]      rd_addr;
  logic                  mem_we;
  logic [IDX_W-1:0]      wr_addr;
  logic [VALUE_BITS-1:0] wr_data;

  // control and working registers
  bst_pkg::state_t              state, state_next;
  logic [CNT_W-1:0]             count, count_next;
  logic [CNT_W-1:0]             iss_idx, iss_idx_next;
  logic [IDX_W-1:0]             cmp_idx, cmp_idx_next;
  logic                         cmp_valid, cmp_valid_next;
  logic [IDX_W-1:0]             hit_idx, hit_idx_next;
  logic [bst_pkg::CMD_W-1:0]    cmd_q, cmd_q_next;
  logic [VALUE_BITS-1:0]        key, key_next;
  logic [bst_pkg::STATUS_W-1:0] res_status, res_status_next;
  logic [bst_pkg::POS_W-1:0]    res_pos, res_pos_next;

  // helpers
  logic                              cmd_beat;
  logic                              is_full;
  logic                              hit;
  logic                              issue;
  logic [CNT_W-1:0]                  last_cnt;
  logic [2*bst_pkg::VALUE_W-1:0]     value_ext;
  logic [VALUE_BITS-1:0]             cmd_key;
  logic [IDX_W+bst_pkg::POS_W-1:0]   cmp_pos_ext;
  logic [CNT_W+bst_pkg::POS_W-1:0]   cnt_pos_ext;
  logic [CNT_W+bst_pkg::SIZE_W-1:0]  size_ext;

  assign cmd_beat    = cmd.valid && cmd.ready;
  assign is_full     = (count >= CNT_W'(CAPACITY));
  assign hit         = cmp_valid && (rd_data == key);
  assign issue       = (state == bst_pkg::S_SCAN) && !hit && (iss_idx < count);
  assign last_cnt    = count - CNT_W'(1);
  assign value_ext   = {{bst_pkg::VALUE_W{1'b0}}, cmd.value};
  assign cmd_key     = value_ext[VALUE_BITS-1:0];
  assign cmp_pos_ext = {{bst_pkg::POS_W{1'b0}}, cmp_idx};
  assign cnt_pos_ext = {{bst_pkg::POS_W{1'b0}}, count};
  assign size_ext    = {{bst_pkg::SIZE_W{1'b0}}, count};

  // memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bst_pkg::S_IDLE: begin
        if (cmd_beat) begin
          if (cmd.command == bst_pkg::CMD_CLEAR ||
              (cmd.command == bst_pkg::CMD_ADD && is_full)) begin
            state_next = bst_pkg::S_RESP;
          end else begin
            state_next = bst_pkg::S_SCAN;
          end
        end
      end
      bst_pkg::S_SCAN: begin
        if (hit) begin
          state_next = (cmd_q == bst_pkg::CMD_REMOVE) ? bst_pkg::S_MOVE_RD
                                                      : bst_pkg::S_RESP;
        end else if (iss_idx == count) begin
          state_next = bst_pkg::S_RESP;
        end
      end
      bst_pkg::S_MOVE_RD: state_next = bst_pkg::S_MOVE_WR;
      bst_pkg::S_MOVE_WR: state_next = bst_pkg::S_RESP;
      bst_pkg::S_RESP: begin
        if (res.ready) begin
          state_next = bst_pkg::S_IDLE;
        end
      end
      default: state_next = bst_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_next      = count;
    iss_idx_next    = iss_idx;
    cmp_idx_next    = cmp_idx;
    cmp_valid_next  = 1'b0;
    hit_idx_next    = hit_idx;
    cmd_q_next      = cmd_q;
    key_next        = key;
    res_status_next = res_status;
    res_pos_next    = res_pos;
    rd_addr         = iss_idx[IDX_W-1:0];
    mem_we          = 1'b0;
    wr_addr         = hit_idx;
    wr_data         = rd_data;
    case (state)
      bst_pkg::S_IDLE: begin
        iss_idx_next = '0;
        if (cmd_beat) begin
          cmd_q_next      = cmd.command;
          key_next        = cmd_key;
          res_status_next = bst_pkg::STAT_OK;
          res_pos_next    = '0;
          if (cmd.command == bst_pkg::CMD_CLEAR) begin
            count_next = '0;
          end else if (cmd.command == bst_pkg::CMD_ADD && is_full) begin
            res_status_next = bst_pkg::STAT_FULL;
          end
        end
      end
      bst_pkg::S_SCAN: begin
        // pipelined scan: issue entry i while comparing entry i-1
        if (issue) begin
          iss_idx_next   = iss_idx + CNT_W'(1);
          cmp_idx_next   = iss_idx[IDX_W-1:0];
          cmp_valid_next = 1'b1;
        end
        if (hit) begin
          case (cmd_q)
            bst_pkg::CMD_ADD: begin
              res_status_next = bst_pkg::STAT_DUP;
            end
            bst_pkg::CMD_REMOVE: begin
              hit_idx_next = cmp_idx;
              res_pos_next = cmp_pos_ext[bst_pkg::POS_W-1:0];
            end
            default: begin
              res_pos_next = cmp_pos_ext[bst_pkg::POS_W-1:0];
            end
          endcase
        end else if (iss_idx == count) begin
          // scan ended without a match
          if (cmd_q == bst_pkg::CMD_ADD) begin
            mem_we       = 1'b1;
            wr_addr      = count[IDX_W-1:0];
            wr_data      = key;
            count_next   = count + CNT_W'(1);
            res_pos_next = cnt_pos_ext[bst_pkg::POS_W-1:0];
          end else begin
            res_status_next = bst_pkg::STAT_MISSING;
          end
        end
      end
      bst_pkg::S_MOVE_RD: begin
        // fetch the last entry
        rd_addr = last_cnt[IDX_W-1:0];
      end
      bst_pkg::S_MOVE_WR: begin
        // move it into the freed slot
        mem_we     = 1'b1;
        wr_addr    = hit_idx;
        wr_data    = rd_data;
        count_next = last_cnt;
      end
      default: begin
      end
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bst_pkg::S_IDLE;
      count     <= '0;
      cmp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      cmp_valid <= cmp_valid_next;
    end
    iss_idx    <= iss_idx_next;
    cmp_idx    <= cmp_idx_next;
    hit_idx    <= hit_idx_next;
    cmd_q      <= cmd_q_next;
    key        <= key_next;
    res_status <= res_status_next;
    res_pos    <= res_pos_next;
  end

  // channel outputs
  assign cmd.ready    = (state == bst_pkg::S_IDLE);
  assign res.valid    = (state == bst_pkg::S_RESP);
  assign res.status   = res_status;
  assign res.position = res_pos;
  assign res.size     = size_ext[bst_pkg::SIZE_W-1:0];

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (cmd_beat && cmd.command == bst_pkg::CMD_CLEAR) |=> (count == '0))
    else $error("clear left entries behind");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (32'(wr_addr) < CAPACITY))
    else $error("memory write outside capacity");

  a_reject_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (res.valid && (res.status == bst_pkg::STAT_FULL ||
     res.status == bst_pkg::STAT_DUP || res.status == bst_pkg::STAT_MISSING))
    |-> !mem_we)
    else $error("rejected command wrote the memory");

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// testbench: self-checking bench for bounded_set_table_top.
// Uses bst_pkg, bst_cmd_if, bst_res_if. A class ledger predicts each result from
// a local copy of the set, while plain tasks drive the command channel.
`timescale 1ns / 1ps

module testbench;

  localparam int TABLE_DEPTH = 16;
  localparam int POOL_SIZE   = 20;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [bst_pkg::STATUS_W-1:0] status;
    logic [bst_pkg::POS_W-1:0]    position;
    logic [bst_pkg::SIZE_W-1:0]   size;
  } set_result_t;

  // Mirror of the set contents plus the queue of results still owed by the block
  class set_table_ledger;
    logic [bst_pkg::VALUE_W-1:0] held[TABLE_DEPTH];
    int                          held_count;
    set_result_t                 expected_results[$];
    int                          failures;

    function new();
      held_count = 0;
      failures   = 0;
    endfunction

    function int slot_of(logic [bst_pkg::VALUE_W-1:0] v);
      for (int i = 0; i < held_count; i++)
        if (held[i] == v) return i;
      return -1;
    endfunction

    function int outstanding();
      return expected_results.size();
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
    endfunction

    // Predict the result of one accepted command beat and update the mirror
    function void note_command(logic [bst_pkg::CMD_W-1:0] c,
                               logic [bst_pkg::VALUE_W-1:0] v);
      set_result_t r;
      int          idx;
      r   = '0;
      idx = slot_of(v);
      case (c)
        bst_pkg::CMD_ADD: begin
          // room is checked before duplicates
          if (held_count >= TABLE_DEPTH) begin
            r.status = bst_pkg::STAT_FULL;
          end else if (idx >= 0) begin
            r.status = bst_pkg::STAT_DUP;
          end else begin
            held[held_count] = v;
            r.position = bst_pkg::POS_W'(held_count);
            held_count++;
          end
        end
        bst_pkg::CMD_REMOVE: begin
          if (idx < 0) begin
            r.status = bst_pkg::STAT_MISSING;
          end else begin
            // last entry fills the freed slot
            held_count--;
            held[idx] = held[held_count];
            r.position = bst_pkg::POS_W'(idx);
          end
        end
        bst_pkg::CMD_LOOKUP: begin
          if (idx < 0) r.status = bst_pkg::STAT_MISSING;
          else r.position = bst_pkg::POS_W'(idx);
        end
        default: held_count = 0;
      endcase
      r.size = bst_pkg::SIZE_W'(held_count);
      expected_results = {expected_results, r};
    endfunction

    function void check_result(set_result_t got);
      set_result_t want;
      if (expected_results.size() == 0) begin
        flag($sformatf("result beat with nothing pending: status=%0d pos=%0d size=%0d",
                       got.status, got.position, got.size));
        return;
      end
      want = expected_results.pop_front();
      if (got.status != want.status || got.position != want.position ||
          got.size != want.size)
        flag($sformatf("exp status=%0d pos=%0d size=%0d, got status=%0d pos=%0d size=%0d",
                       want.status, want.position, want.size,
                       got.status, got.position, got.size));
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycle_count;
  int   stall_left;
  bit   gaps_on;
  bit   stalls_on;
  logic [bst_pkg::VALUE_W-1:0] value_pool[POOL_SIZE];
  set_table_ledger             ledger;

  bst_cmd_if cmd_ch();
  bst_res_if res_ch();

  bounded_set_table_top #(
    .CAPACITY  (TABLE_DEPTH),
    .VALUE_BITS(bst_pkg::VALUE_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[bounded_set_table_top] ERROR");
      $finish;
    end
  end

  // Result side: check accepted beats, then drop ready in short random bursts
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      ledger.check_result('{res_ch.status, res_ch.position, res_ch.size});
    if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left--;
    end else if (stalls_on && $urandom_range(0, 4) == 0) begin
      res_ch.ready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // One command beat; valid stays high unless a gap follows
  task automatic send_cmd(input logic [bst_pkg::CMD_W-1:0] c,
                          input logic [bst_pkg::VALUE_W-1:0] v);
    cmd_ch.valid   <= 1'b1;
    cmd_ch.command <= c;
    cmd_ch.value   <= v;
    do @(posedge clk); while (!cmd_ch.ready);
    ledger.note_command(c, v);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic hold_until_drained();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (ledger.outstanding() != 0);
  endtask

  function automatic logic [bst_pkg::VALUE_W-1:0] pick_value();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return value_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic logic [bst_pkg::CMD_W-1:0] pick_command(int add_w, int rem_w,
                                                             int look_w);
    int r;
    r = $urandom_range(0, 99);
    if (r < add_w) return bst_pkg::CMD_ADD;
    if (r < add_w + rem_w) return bst_pkg::CMD_REMOVE;
    if (r < add_w + rem_w + look_w) return bst_pkg::CMD_LOOKUP;
    return bst_pkg::CMD_CLEAR;
  endfunction

  // Empty-set misses, duplicates, swap-in removal, fill to capacity, full rejects
  task automatic run_directed();
    send_cmd(bst_pkg::CMD_LOOKUP, 32'h0);
    send_cmd(bst_pkg::CMD_REMOVE, 32'h0);
    send_cmd(bst_pkg::CMD_ADD, 32'h0);
    send_cmd(bst_pkg::CMD_ADD, 32'hFFFF_FFFF);
    send_cmd(bst_pkg::CMD_ADD, 32'h0);
    send_cmd(bst_pkg::CMD_LOOKUP, 32'hFFFF_FFFF);
    send_cmd(bst_pkg::CMD_REMOVE, 32'h0);
    send_cmd(bst_pkg::CMD_LOOKUP, 32'hFFFF_FFFF);
    send_cmd(bst_pkg::CMD_REMOVE, 32'h1234_5678);
    send_cmd(bst_pkg::CMD_CLEAR, 32'hDEAD_BEEF);
    send_cmd(bst_pkg::CMD_CLEAR, 32'h0);
    send_cmd(bst_pkg::CMD_ADD, 32'h0);
    send_cmd(bst_pkg::CMD_ADD, 32'hFFFF_FFFF);
    for (int k = 0; k < TABLE_DEPTH - 2; k++)
      send_cmd(bst_pkg::CMD_ADD, (32'h1 << (2 * k + 1)) ^ 32'hA5A5_5A5A);
    send_cmd(bst_pkg::CMD_ADD, 32'h7777_7777);
    send_cmd(bst_pkg::CMD_ADD, 32'h0);
    send_cmd(bst_pkg::CMD_REMOVE, 32'hFFFF_FFFF);
    send_cmd(bst_pkg::CMD_CLEAR, 32'h0);
  endtask

  // Four blocks with different command mixes; the last one runs flat out
  task automatic run_random();
    int add_w;
    int rem_w;
    int look_w;
    for (int blk = 0; blk < 4; blk++) begin
      case (blk)
        0: begin add_w = 60; rem_w = 15; look_w = 23; gaps_on = 1; stalls_on = 1; end
        1: begin add_w = 35; rem_w = 35; look_w = 28; gaps_on = 0; stalls_on = 1; end
        2: begin add_w = 45; rem_w = 25; look_w = 27; gaps_on = 1; stalls_on = 0; end
        default: begin
          add_w = 45; rem_w = 28; look_w = 25; gaps_on = 0; stalls_on = 0;
        end
      endcase
      for (int n = 0; n < 200; n++)
        send_cmd(pick_command(add_w, rem_w, look_w), pick_value());
      if (blk == 1) hold_until_drained();
    end
  endtask

  initial begin
    rst            = 1'b1;
    cmd_ch.valid   = 1'b0;
    cmd_ch.command = bst_pkg::CMD_ADD;
    cmd_ch.value   = '0;
    res_ch.ready   = 1'b0;
    cycle_count    = 0;
    stall_left     = 0;
    gaps_on        = 1;
    stalls_on      = 1;
    ledger         = new();
    value_pool[0]  = '0;
    value_pool[1]  = '1;
    for (int i = 2; i < POOL_SIZE; i++) value_pool[i] = $urandom();

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    run_random();
    cmd_ch.valid <= 1'b0;

    // drain, then allow a full remove's latency for stray beats
    do @(posedge clk); while (ledger.outstanding() != 0);
    repeat (30) @(posedge clk);

    if (ledger.failures == 0 && ledger.outstanding() == 0)
      $display("[bounded_set_table_top] OK");
    else
      $display("[bounded_set_table_top] ERROR");
    $finish;
  end

endmodule
